// ===== rtl/counting_semaphore_table_top_assert.svh =====
// assertion macros shared by the semaphore table checker
// no dependencies
`ifndef COUNTING_SEMAPHORE_TABLE_TOP_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_TOP_ASSERT_SVH
// implication checked on every clock, off in reset
`define CST_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// next-cycle implication
`define CST_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

// ===== rtl/cst_pkg.sv =====
// package for the counting semaphore table: codes and defaults
// no dependencies
package cst_pkg;
    localparam int DEF_USER_SEMS   = 16;
    localparam int DEF_TOTAL_SEMS  = 32;
    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int DEF_PROCESSES   = 256;
    localparam int MAX_RESULTS     = 8;

    typedef enum logic [2:0] {
        M_OPEN = 3'd0, M_OPEN_ANY = 3'd1, M_WAIT = 3'd2, M_POST = 3'd3,
        M_POST_ZERO = 3'd4, M_CLOSE = 3'd5, M_REMOVE = 3'd6, M_NOP = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_BAD_ID = 3'd1, ST_NOT_OPEN = 3'd2,
        ST_QUEUE_FULL = 3'd3, ST_NO_FREE = 3'd4
    } t_status;
endpackage

// ===== rtl/counting_semaphore_table_top.sv =====
// top level of the counting semaphore table
// depends on cst_pkg
//
// channel   direction  handshake             payload
// request   in         i_start & !o_busy     mode sem_id kernel_range init_value process_id
// result    out        o_valid (one cycle)   status granted blocked woken_* assigned_id last
//
// a request holds o_busy from its accepting edge until its result; the result
// shows in the first cycle with o_busy low, so the next transaction can be taken
// at the edge that ends it
// mode 7 and rejected ids answer straight from idle, plain requests after a
// decode state, a post that wakes after decode, peek and pop; open-any scans
// user ids one per cycle, remove reads the mark then scans and shifts the
// queue one slot per cycle, and last close pops waiters through peek and pop
// with one result each; reset is synchronous; the per-process waiting marks
// are cleared by a sweep of all PROCESSES entries after reset, with o_busy high meanwhile
// results cannot be stalled by the receiver
module counting_semaphore_table_top import cst_pkg::*; #(
    parameter int USER_SEMS   = DEF_USER_SEMS,
    parameter int TOTAL_SEMS  = DEF_TOTAL_SEMS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int PROCESSES   = DEF_PROCESSES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_mode,
    input  logic [5:0]  i_sem_id,
    input  logic        i_kernel_range,
    input  logic [31:0] i_init_value,
    input  logic [7:0]  i_process_id,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic        o_granted,
    output logic        o_blocked,
    output logic        o_woken_valid,
    output logic [7:0]  o_woken_process,
    output logic [5:0]  o_assigned_id,
    output logic        o_last
);
    localparam int QCAP     = (QUEUE_DEPTH < MAX_RESULTS) ? QUEUE_DEPTH : MAX_RESULTS;
    localparam int USER_LIM = (USER_SEMS < TOTAL_SEMS) ? USER_SEMS : TOTAL_SEMS;
    localparam int SW  = (TOTAL_SEMS > 1) ? $clog2(TOTAL_SEMS) : 1;
    localparam int QW  = (QCAP > 1) ? $clog2(QCAP) : 1;
    localparam int LW  = $clog2(QCAP + 1);
    localparam int PW  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int PCW = $clog2(PROCESSES + 1);
    localparam int AW  = SW + QW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_RD_MARK, S_RM_FIND, S_RM_SHIFT,
        S_PEEK, S_POP
    } t_state;

    // per semaphore tables (small, flip-flops)
    logic [31:0]   r_count  [TOTAL_SEMS];
    logic [7:0]    r_refs   [TOTAL_SEMS];
    logic [QW-1:0] r_head   [TOTAL_SEMS];
    logic [LW-1:0] r_len    [TOTAL_SEMS];
    // waiter slots and per-process marks are memories
    logic [7:0]    r_slots  [TOTAL_SEMS*QCAP];
    logic [6:0]    r_marks  [PROCESSES];   // {flag, sem}
    logic [7:0]    r_slot_q;
    logic [6:0]    r_mark_q;

    t_state        r_state;
    logic [2:0]    r_mode;
    logic [SW-1:0] r_sem;
    logic [31:0]   r_init;
    logic [7:0]    r_pid;
    logic [LW-1:0] r_idx;
    logic [PCW-1:0] r_clr;

    logic          r_valid;
    logic [2:0]    r_status;
    logic          r_granted, r_blocked, r_wv, r_last;
    logic [7:0]    r_wp;
    logic [5:0]    r_aid;

    // shared memory port controls
    logic          slot_we;
    logic [AW-1:0] slot_wa, slot_ra;
    logic [7:0]    slot_wd;
    logic          mark_we;
    logic [PW-1:0] mark_wa, mark_ra;
    logic [6:0]    mark_wd;

    // head plus offset stays below twice the depth, so one subtract wraps it
    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
                                                input logic [QW-1:0] h,
                                                input logic [LW-1:0] i);
        logic [LW:0] sum;
        logic [QW-1:0] off;
        begin
            sum = {{(LW+1-QW){1'b0}}, h} + {1'b0, i};
            off = (sum >= (LW+1)'(QCAP)) ? QW'(sum - (LW+1)'(QCAP)) : QW'(sum);
            slot_addr = AW'(({{(AW-SW){1'b0}}, s} * AW'(QCAP)) + {{(AW-QW){1'b0}}, off});
        end
    endfunction

    logic id_ok;
    assign id_ok = i_kernel_range ? (32'(i_sem_id) >= USER_LIM && 32'(i_sem_id) < TOTAL_SEMS)
                                  : (32'(i_sem_id) < USER_LIM);

    always_ff @(posedge i_clk) begin
        if (slot_we) r_slots[slot_wa] <= slot_wd;
        r_slot_q <= r_slots[slot_ra];
        if (mark_we) r_marks[mark_wa] <= mark_wd;
        r_mark_q <= r_marks[mark_ra];
    end

    logic [SW-1:0] msem;
    assign msem = r_mark_q[SW-1:0];
    logic mark_here;
    assign mark_here = r_mark_q[6] && (r_mark_q[5:0] == 6'(r_sem));

    always_comb begin
        slot_we = 1'b0; slot_wa = '0; slot_wd = r_slot_q;
        slot_ra = slot_addr(r_sem, r_head[r_sem], r_idx);
        mark_we = 1'b0; mark_wa = r_pid[PW-1:0]; mark_wd = '0;
        mark_ra = r_pid[PW-1:0];
        case (r_state)
            S_CLEAR: begin
                mark_we = 1'b1; mark_wa = r_clr[PW-1:0];
            end
            S_IDLE: mark_ra = i_process_id[PW-1:0];
            S_DECODE: begin
                if (r_mode == M_WAIT && 32'(r_pid) < PROCESSES && r_refs[r_sem] != 0
                    && r_count[r_sem] == 0 && r_len[r_sem] < LW'(QCAP)) begin
                    slot_we = 1'b1;
                    slot_wa = slot_addr(r_sem, r_head[r_sem], r_len[r_sem]);
                    slot_wd = r_pid;
                    mark_we = 1'b1;
                    mark_wd = {1'b1, 6'(r_sem)};
                end
                if (r_mode == M_REMOVE) begin
                    // a removed process is no longer waiting, found or not
                    slot_ra = slot_addr(msem, r_head[msem], '0);
                    mark_we = r_mark_q[6];
                end
                if (r_mode == M_POST || r_mode == M_POST_ZERO || r_mode == M_CLOSE)
                    slot_ra = slot_addr(r_sem, r_head[r_sem], '0);
            end
            S_RM_FIND: slot_ra = slot_addr(r_sem, r_head[r_sem], r_idx + LW'(1));
            S_RM_SHIFT: begin
                slot_ra = slot_addr(r_sem, r_head[r_sem], r_idx + LW'(2));
                slot_we = 1'b1;
                slot_wa = slot_addr(r_sem, r_head[r_sem], r_idx);
            end
            S_PEEK: mark_ra = r_slot_q[PW-1:0];
            S_POP: begin
                mark_ra = r_slot_q[PW-1:0];
                mark_wa = r_pid[PW-1:0];
                mark_we = mark_here;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            for (int s = 0; s < TOTAL_SEMS; s++) begin
                r_count[s] <= '0; r_refs[s] <= '0; r_head[s] <= '0; r_len[s] <= '0;
            end
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + PCW'(1);
                    if (r_clr == PCW'(PROCESSES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_start) begin
                    r_mode <= i_mode; r_init <= i_init_value; r_pid <= i_process_id;
                    r_sem <= SW'(i_sem_id); r_idx <= '0;
                    {r_status, r_granted, r_blocked, r_wv, r_wp, r_aid} <= '0;
                    r_last <= 1'b1;
                    r_state <= S_DECODE;
                    if (i_mode == M_OPEN_ANY) begin
                        r_sem <= '0; r_state <= S_SCAN;
                    end else if (i_mode == M_REMOVE) begin
                        if (32'(i_process_id) >= PROCESSES) begin
                            r_status <= ST_BAD_ID; r_valid <= 1'b1; r_state <= S_IDLE;
                        end else r_state <= S_RD_MARK;
                    end else if (i_mode == M_NOP) begin
                        r_valid <= 1'b1; r_state <= S_IDLE;
                    end else if (!id_ok) begin
                        r_status <= ST_BAD_ID; r_valid <= 1'b1; r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    // one user id per cycle
                    if (r_refs[r_sem] == 0) begin
                        r_refs[r_sem] <= 8'd1; r_count[r_sem] <= r_init;
                        r_head[r_sem] <= '0; r_len[r_sem] <= '0;
                        r_aid <= 6'(r_sem); r_valid <= 1'b1; r_state <= S_IDLE;
                    end else if (32'(r_sem) == USER_LIM - 1) begin
                        r_status <= ST_NO_FREE; r_valid <= 1'b1; r_state <= S_IDLE;
                    end else r_sem <= r_sem + SW'(1);
                end
                S_RD_MARK: r_state <= S_DECODE;
                S_DECODE: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b1;
                    if (r_mode == M_REMOVE) begin
                        if (r_mark_q[6] && 32'(r_mark_q[5:0]) < TOTAL_SEMS) begin
                            r_sem <= msem;
                            if (r_len[msem] != 0) begin
                                r_valid <= 1'b0; r_state <= S_RM_FIND;
                            end
                        end
                    end else if (r_mode == M_OPEN) begin
                        if (r_refs[r_sem] != 0) begin
                            if (r_refs[r_sem] != 8'hFF) r_refs[r_sem] <= r_refs[r_sem] + 8'd1;
                        end else begin
                            r_refs[r_sem] <= 8'd1; r_count[r_sem] <= r_init;
                            r_head[r_sem] <= '0; r_len[r_sem] <= '0;
                        end
                    end else if (r_refs[r_sem] == 0) begin
                        r_status <= ST_NOT_OPEN;
                    end else if (r_mode == M_WAIT) begin
                        if (32'(r_pid) >= PROCESSES) r_status <= ST_BAD_ID;
                        else if (r_count[r_sem] != 0) begin
                            r_count[r_sem] <= r_count[r_sem] - 32'd1; r_granted <= 1'b1;
                        end else if (r_len[r_sem] >= LW'(QCAP)) r_status <= ST_QUEUE_FULL;
                        else begin
                            r_len[r_sem] <= r_len[r_sem] + LW'(1); r_blocked <= 1'b1;
                        end
                    end else if (r_mode == M_POST || r_mode == M_POST_ZERO) begin
                        if (r_mode == M_POST_ZERO && r_count[r_sem] != 0) ;
                        else if (r_len[r_sem] == 0) begin
                            if (r_count[r_sem] != 32'hFFFF_FFFF)
                                r_count[r_sem] <= r_count[r_sem] + 32'd1;
                        end else begin
                            r_valid <= 1'b0; r_state <= S_PEEK;
                        end
                    end else begin
                        r_refs[r_sem] <= r_refs[r_sem] - 8'd1;
                        if (r_refs[r_sem] == 8'd1 && r_len[r_sem] != 0) begin
                            r_valid <= 1'b0; r_state <= S_PEEK;
                        end
                    end
                end
                S_RM_FIND: begin
                    // r_slot_q holds slot r_idx
                    if (r_slot_q == r_pid) begin
                        if (r_idx + LW'(1) >= r_len[r_sem]) begin
                            r_len[r_sem] <= r_len[r_sem] - LW'(1);
                            r_valid <= 1'b1; r_state <= S_IDLE;
                        end else r_state <= S_RM_SHIFT;
                    end else if (r_idx + LW'(1) >= r_len[r_sem]) begin
                        r_valid <= 1'b1; r_state <= S_IDLE;
                    end else r_idx <= r_idx + LW'(1);
                end
                S_RM_SHIFT: begin
                    // write slot idx from slot idx+1 (now in r_slot_q)
                    if (r_idx + LW'(2) >= r_len[r_sem]) begin
                        r_len[r_sem] <= r_len[r_sem] - LW'(1);
                        r_valid <= 1'b1; r_state <= S_IDLE;
                    end else r_idx <= r_idx + LW'(1);
                end
                S_PEEK: begin
                    // head pid in r_slot_q; its mark is read here
                    r_pid <= r_slot_q;
                    r_wp  <= r_slot_q;
                    r_head[r_sem] <= QW'((LW+1)'(r_head[r_sem]) + (LW+1)'(1)) == QW'(QCAP)
                        ? '0 : r_head[r_sem] + QW'(1);
                    r_len[r_sem] <= r_len[r_sem] - LW'(1);
                    r_state <= S_POP;
                end
                S_POP: begin
                    // clear the mark (port), emit, next head already readable
                    r_wv <= 1'b1;
                    r_valid <= 1'b1;
                    r_last <= (r_mode != M_CLOSE) || (r_len[r_sem] == 0);
                    if (r_mode == M_CLOSE && r_len[r_sem] != 0) r_state <= S_PEEK;
                    else r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_granted       = r_granted;
    assign o_blocked       = r_blocked;
    assign o_woken_valid   = r_wv;
    assign o_woken_process = r_wp;
    assign o_assigned_id   = r_aid;
    assign o_last          = r_last;
endmodule

// ===== rtl/cst_checker.sv =====
// port checker for the semaphore table, bound to the top level
// depends on cst_pkg and the assertion macro header
`include "counting_semaphore_table_top_assert.svh"
module cst_checker import cst_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_valid,
    input logic [2:0] o_status,
    input logic       o_granted,
    input logic       o_blocked,
    input logic       o_woken_valid,
    input logic       o_last
);
    `CST_ASSERT_IMP(a_one_outcome, i_clk, i_rst_n, o_valid, !(o_granted && o_blocked))
    `CST_ASSERT_IMP(a_grant_ok, i_clk, i_rst_n, o_valid && (o_granted || o_blocked),
        o_status == ST_OK)
    `CST_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy || o_valid)
    `CST_ASSERT_IMP(a_last_frees, i_clk, i_rst_n, o_valid && o_last, !o_busy)
endmodule

bind counting_semaphore_table_top cst_checker u_cst_checker (.*);
